// ===== design/lbs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lbs_pkg
// Shared types and constants of the linear blend skinning pipeline.
// ----------------------------------------------------------------------------
package lbs_pkg;
  localparam int MAX_BONES = 128;
  localparam int BONE_W    = $clog2(MAX_BONES);
  localparam int MAT_WORDS = 12;
  localparam int ELEM_W    = 4;
  localparam int SLOTS     = 4;
  localparam int IN_W      = 240;
  localparam int OUT_W     = 96;
  localparam logic [7:0] SLOT_EMPTY = 8'hFF;
  localparam logic [7:0] BONE_LIMIT = 8'(MAX_BONES);
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_SKIN = 1'b1;

  typedef logic signed [31:0] q16_t;
  typedef logic [15:0] wgt_t;

  typedef struct packed {
    logic en1;
    logic en2;
    logic en3;
    logic en4;
    logic en5;
  } lbs_stall_t;
endpackage
`default_nettype wire

// ===== design/lbs_bank.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lbs_bank
// One copy of the bone matrix table, one memory per matrix element, so a
// whole 3x4 matrix is read at one bone address per cycle while rd_en is high.
// ----------------------------------------------------------------------------
module lbs_bank (
  input  wire logic                          clk,
  input  wire logic                          rd_en,
  input  wire logic [lbs_pkg::BONE_W-1:0]    rd_addr,
  input  wire logic                          wr_en,
  input  wire logic [lbs_pkg::ELEM_W-1:0]    wr_elem,
  input  wire logic [lbs_pkg::BONE_W-1:0]    wr_addr,
  input  wire logic [31:0]                   wr_data,
  output lbs_pkg::q16_t [lbs_pkg::MAT_WORDS-1:0] rd_data
);
  import lbs_pkg::*;

  for (genvar e = 0; e < MAT_WORDS; e++) begin : g_elem
    logic [31:0] mem [MAX_BONES];
    always_ff @(posedge clk) begin
      if (wr_en && wr_elem == ELEM_W'(e)) begin
        mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
        rd_data[e] <= mem[rd_addr];
      end
    end
  end
endmodule
`default_nettype wire

// ===== design/lbs_xform.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lbs_xform
// Affine 3x4 matrix times point for one slot: products, then row sums
// with saturation.
// ----------------------------------------------------------------------------
module lbs_xform (
  input  wire logic                              clk,
  input  wire lbs_pkg::lbs_stall_t               stall,
  input  wire lbs_pkg::q16_t [lbs_pkg::MAT_WORDS-1:0] m,
  input  wire lbs_pkg::q16_t [2:0]               p,
  input  wire logic                              active,
  output lbs_pkg::q16_t [2:0]                    t
);
  import lbs_pkg::*;

  logic signed [63:0] prod [3][3];
  q16_t               ofs [3];

  for (genvar r = 0; r < 3; r++) begin : g_row
    logic signed [49:0] s;
    always_comb begin
      s = 50'($signed(prod[r][0][63:16])) + 50'($signed(prod[r][1][63:16]))
        + 50'($signed(prod[r][2][63:16])) + 50'(ofs[r]);
    end
    always_ff @(posedge clk) begin
      if (stall.en2) begin
        for (int c = 0; c < 3; c++) begin
          prod[r][c] <= (active ? m[r*4+c] : q16_t'(0)) * p[c];
        end
        ofs[r] <= active ? m[r*4+3] : q16_t'(0);
      end
      if (stall.en3) begin
        if (s > 50'sd2147483647)       t[r] <= 32'sh7FFFFFFF;
        else if (s < -50'sd2147483648) t[r] <= 32'sh80000000;
        else                           t[r] <= s[31:0];
      end
    end
  end
endmodule
`default_nettype wire

// ===== design/lbs_blend.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lbs_blend
// Weighted sum of the transformed slot positions, rounding to Q16.16 with
// saturation, and selection of the raw position on pass-through.
// ----------------------------------------------------------------------------
module lbs_blend (
  input  wire logic                   clk,
  input  wire lbs_pkg::lbs_stall_t    stall,
  input  wire lbs_pkg::q16_t [11:0]   t,
  input  wire lbs_pkg::wgt_t [3:0]    w,
  input  wire lbs_pkg::q16_t [2:0]    pos,
  input  wire logic                   pass,
  output lbs_pkg::q16_t [2:0]         res
);
  import lbs_pkg::*;

  logic signed [48:0] prod [3][SLOTS];

  for (genvar r = 0; r < 3; r++) begin : g_row
    logic signed [51:0] s;
    logic signed [36:0] f;
    always_comb begin
      s = 52'(prod[r][0]) + 52'(prod[r][1]) + 52'(prod[r][2]) + 52'(prod[r][3])
        + 52'sd16384;
      f = s[51:15];
    end
    always_ff @(posedge clk) begin
      if (stall.en4) begin
        for (int k = 0; k < SLOTS; k++) begin
          prod[r][k] <= t[k*3+r] * $signed({1'b0, w[k]});
        end
      end
      if (stall.en5) begin
        if (pass)                        res[r] <= pos[r];
        else if (f > 37'sd2147483647)    res[r] <= 32'sh7FFFFFFF;
        else if (f < -37'sd2147483648)   res[r] <= 32'sh80000000;
        else                             res[r] <= f[31:0];
      end
    end
  end
endmodule
`default_nettype wire

// ===== design/linear_blend_skinning.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// linear_blend_skinning
// Four-influence skinning of Q16.16 vertices against a 128-bone table of
// 3x4 affine matrices.
// ----------------------------------------------------------------------------
// One request enters per cycle while s_tready is high, loads and vertices
// alike. A vertex passes five register stages before its result is valid
// at the output. The bone table is held as four copies, one per influence
// slot, each split into twelve element memories, so all 48 matrix words of
// a vertex are read in the cycle it is accepted; a load request writes the
// element into all four copies. Loads return nothing. The table has no
// reset: skin only against bones whose matrices were loaded. Each stage
// advances when the next one is empty or moving.
module linear_blend_skinning (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      cfg_valid,
  output logic                           cfg_ready,
  input  wire logic [7:0]                cfg_data,   // bone_count
  input  wire logic                      s_tvalid,
  output logic                           s_tready,
  // matrix_bone, matrix_element, matrix_value, pos_x, pos_y, pos_z,
  // slot_ids, weight_a, weight_b, weight_c, weight_d
  input  wire logic [lbs_pkg::IN_W-1:0]  s_tdata,
  input  wire logic                      s_tuser,    // command
  output logic                           m_tvalid,
  input  wire logic                      m_tready,
  output logic [lbs_pkg::OUT_W-1:0]      m_tdata,    // out_x, out_y, out_z
  output logic                           m_tuser     // passed_through
);
  import lbs_pkg::*;

  logic [7:0]  bone_count;
  logic [7:0]  limit;
  lbs_stall_t  stall;
  logic        v1, v2, v3, v4, v5;
  logic        acc_in, wr_en;
  logic [7:0]  id [SLOTS];
  logic [SLOTS-1:0] act_in;
  logic        pass_in;
  q16_t [2:0]  pos_in;
  wgt_t [3:0]  w_in;

  q16_t [2:0]  pos1, pos2, pos3, pos4;
  wgt_t [3:0]  w1, w2, w3;
  logic        pass1, pass2, pass3, pass4;
  logic [SLOTS-1:0] act1;
  q16_t [MAT_WORDS-1:0] mrd [SLOTS];
  q16_t [11:0] t3;
  q16_t [2:0]  res;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      bone_count <= '0;
    end else if (cfg_valid) begin
      bone_count <= cfg_data;
    end
  end
  assign limit = (bone_count > BONE_LIMIT) ? BONE_LIMIT : bone_count;

  assign stall.en5 = !v5 || m_tready;
  assign stall.en4 = !v4 || stall.en5;
  assign stall.en3 = !v3 || stall.en4;
  assign stall.en2 = !v2 || stall.en3;
  assign stall.en1 = !v1 || stall.en2;
  assign s_tready  = stall.en1;
  assign acc_in    = s_tvalid && s_tready;
  assign wr_en     = acc_in && s_tuser == CMD_LOAD &&
                     s_tdata[10:7] < ELEM_W'(MAT_WORDS);

  assign pos_in[0] = s_tdata[74:43];
  assign pos_in[1] = s_tdata[106:75];
  assign pos_in[2] = s_tdata[138:107];
  assign w_in[0]   = s_tdata[186:171];
  assign w_in[1]   = s_tdata[202:187];
  assign w_in[2]   = s_tdata[218:203];
  assign w_in[3]   = s_tdata[234:219];

  always_comb begin
    pass_in = 1'b0;
    for (int k = 0; k < SLOTS; k++) begin
      id[k]     = s_tdata[139+8*k +: 8];
      act_in[k] = id[k] != SLOT_EMPTY;
      if (act_in[k] && id[k] >= limit) pass_in = 1'b1;
    end
    if (!act_in[0]) pass_in = 1'b1;
  end

  for (genvar k = 0; k < SLOTS; k++) begin : g_slot
    lbs_bank u_bank (
      .clk     (clk),
      .rd_en   (stall.en1),
      .rd_addr (id[k][BONE_W-1:0]),
      .wr_en   (wr_en),
      .wr_elem (s_tdata[10:7]),
      .wr_addr (s_tdata[6:0]),
      .wr_data (s_tdata[42:11]),
      .rd_data (mrd[k])
    );
    lbs_xform u_xform (
      .clk    (clk),
      .stall  (stall),
      .m      (mrd[k]),
      .p      (pos1),
      .active (act1[k]),
      .t      (t3[k*3 +: 3])
    );
  end

  lbs_blend u_blend (
    .clk   (clk),
    .stall (stall),
    .t     (t3),
    .w     (w3),
    .pos   (pos4),
    .pass  (pass4),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      if (stall.en1) v1 <= acc_in && s_tuser == CMD_SKIN;
      if (stall.en2) v2 <= v1;
      if (stall.en3) v3 <= v2;
      if (stall.en4) v4 <= v3;
      if (stall.en5) v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (stall.en1) begin
      pos1  <= pos_in;
      pass1 <= pass_in;
      act1  <= pass_in ? '0 : act_in;
      for (int k = 0; k < SLOTS; k++) begin
        w1[k] <= (act_in[k] && !pass_in) ? w_in[k] : '0;
      end
    end
    if (stall.en2) begin
      pos2  <= pos1;
      pass2 <= pass1;
      w2    <= w1;
    end
    if (stall.en3) begin
      pos3  <= pos2;
      pass3 <= pass2;
      w3    <= w2;
    end
    if (stall.en4) begin
      pos4  <= pos3;
      pass4 <= pass3;
    end
    if (stall.en5) begin
      m_tuser <= pass4;
    end
  end

  assign m_tvalid = v5;
  assign m_tdata  = {res[2], res[1], res[0]};

  a_first_stage_free: assert property (@(posedge clk) disable iff (rst)
    !v1 |-> s_tready) else $error("input stalled with empty first stage");
  a_load_no_result: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && s_tuser == CMD_LOAD) |=> !v1)
    else $error("load request produced a result");
  a_stage_hold: assert property (@(posedge clk) disable iff (rst)
    (v4 && !stall.en5) |=> v4) else $error("stalled stage lost its request");
endmodule
`default_nettype wire
